// ===== hdl/uac_pkg.sv =====
// uac_pkg: shared types, opcodes and sizes for the unsigned 64-bit alu core
// no dependencies; every other file of the core refers to it by scoped names
`timescale 1ns / 1ps

package uac_pkg;

	// data path sizes
	localparam int WORD_W      = 64;
	localparam int HALF_W      = 32;
	localparam int SHIFT_W     = 7;
	localparam int OP_W        = 4;

	// sequencing of the long operations
	localparam int DIV_STEPS   = 64;
	localparam int STEP_W      = 6;
	localparam int MUL_STEPS   = 4;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ADD = 4'd0;
	localparam op_t OP_SUB = 4'd1;
	localparam op_t OP_MUL = 4'd2;
	localparam op_t OP_DIV = 4'd3;
	localparam op_t OP_MOD = 4'd4;
	localparam op_t OP_SHL = 4'd5;
	localparam op_t OP_SHR = 4'd6;
	localparam op_t OP_AND = 4'd7;
	localparam op_t OP_INC = 4'd8;
	localparam op_t OP_DEC = 4'd9;

	// which back end unit a request needs
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2
	} class_t;

	// one classified request as it sits in the queue
	typedef struct packed {
		op_t                x_op;
		logic [WORD_W-1:0]  x;
		logic [WORD_W-1:0]  y;
		logic [SHIFT_W-1:0] sh;
		class_t             cls;
		logic               less;
		logic               equal;
	} item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// back end sequencer
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_DIV  = 3'b100
	} back_state_t;

endpackage

// ===== hdl/uac_front.sv =====
// uac_front: accepts requests, classifies the opcode and forms the compare flags
// depends on uac_pkg
`timescale 1ns / 1ps

module uac_front (
	input  logic                        start,
	input  uac_pkg::op_t                op,
	input  logic [uac_pkg::WORD_W-1:0]  operand_x,
	input  logic [uac_pkg::WORD_W-1:0]  operand_y,
	input  logic [uac_pkg::SHIFT_W-1:0] shift_amount,
	input  uac_pkg::q_status_t          q_status,
	output logic                        busy,
	output logic                        push,
	output uac_pkg::item_t              item
);

	uac_pkg::class_t cls;

	// hold off new requests while the queue is full
	assign busy = q_status.full;
	assign push = start && !q_status.full;

	// opcode decoder: pick the back end unit
	always_comb begin
		unique case (op) inside
			uac_pkg::OP_MUL:                 cls = uac_pkg::CLS_MUL;
			uac_pkg::OP_DIV, uac_pkg::OP_MOD: cls = uac_pkg::CLS_DIV;
			default:                         cls = uac_pkg::CLS_SIMPLE;
		endcase
	end

	// pack the request with its compare flags
	always_comb begin
		item.x_op  = op;
		item.x     = operand_x;
		item.y     = operand_y;
		item.sh    = shift_amount;
		item.cls   = cls;
		item.less  = operand_x < operand_y;
		item.equal = operand_x == operand_y;
	end

endmodule

// ===== hdl/uac_queue.sv =====
// uac_queue: short fifo of classified requests between front and back
// depends on uac_pkg
`timescale 1ns / 1ps

module uac_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  uac_pkg::item_t     push_item,
	input  logic               pop,
	output uac_pkg::item_t     head,
	output uac_pkg::q_status_t q_status
);

	uac_pkg::item_t              mem_q [uac_pkg::QUEUE_DEPTH];
	logic [uac_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [uac_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [uac_pkg::QCNT_W-1:0]  count_q;

	localparam logic [uac_pkg::QPTR_W-1:0] PTR_LAST = uac_pkg::QPTR_W'(uac_pkg::QUEUE_DEPTH - 1);
	localparam logic [uac_pkg::QCNT_W-1:0] CNT_FULL = uac_pkg::QCNT_W'(uac_pkg::QUEUE_DEPTH);

	assign q_status.full  = count_q == CNT_FULL;
	assign q_status.empty = count_q == '0;
	assign head           = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/uac_back.sv =====
// uac_back: executes requests; simple ops, a 32x32 multiply sequence
// and a one bit per cycle restoring divider; depends on uac_pkg
`timescale 1ns / 1ps

module uac_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  uac_pkg::item_t             head,
	input  uac_pkg::q_status_t         q_status,
	output logic                       pop,
	output logic                       done,
	output logic [uac_pkg::WORD_W-1:0] value,
	output logic                       less,
	output logic                       equal
);

	localparam int W = uac_pkg::WORD_W;
	localparam int H = uac_pkg::HALF_W;
	localparam logic [uac_pkg::STEP_W-1:0] DIV_LAST = uac_pkg::STEP_W'(uac_pkg::DIV_STEPS - 1);
	localparam logic [uac_pkg::STEP_W-1:0] MUL_LAST = uac_pkg::STEP_W'(uac_pkg::MUL_STEPS - 1);

	uac_pkg::back_state_t        state_q;
	logic [uac_pkg::STEP_W-1:0]  cnt_q;
	logic [W-1:0]                a_q;
	logic [W-1:0]                b_q;
	logic                        is_mod_q;
	logic                        lt_q;
	logic                        eq_q;
	logic [W-1:0]                rem_q;
	logic [W-1:0]                quo_q;
	logic [W-1:0]                prod_q;
	logic [W-1:0]                acc_q;
	logic                        done_q;
	logic [W-1:0]                value_q;
	logic                        less_q;
	logic                        equal_q;

	logic [W-1:0]                simple_val;
	logic [H-1:0]                mul_a;
	logic [H-1:0]                mul_b;
	logic [W-1:0]                mul_prod;
	logic [W-1:0]                acc_sum;
	logic [W:0]                  div_t;
	logic [W+1:0]                div_diff;
	logic                        take;
	logic [W-1:0]                rem_next;
	logic [W-1:0]                quo_next;

	assign pop   = (state_q == uac_pkg::ST_IDLE) && !q_status.empty;
	assign done  = done_q;
	assign value = value_q;
	assign less  = less_q;
	assign equal = equal_q;

	// simple operations, combinational from the queue head
	always_comb begin
		case (head.x_op)
			uac_pkg::OP_ADD: simple_val = head.x + head.y;
			uac_pkg::OP_SUB: simple_val = head.x - head.y;
			uac_pkg::OP_SHL: simple_val = head.sh[uac_pkg::SHIFT_W-1] ? '0 :
				head.x << head.sh[uac_pkg::SHIFT_W-2:0];
			uac_pkg::OP_SHR: simple_val = head.sh[uac_pkg::SHIFT_W-1] ? '0 :
				head.x >> head.sh[uac_pkg::SHIFT_W-2:0];
			uac_pkg::OP_AND: simple_val = head.x & head.y;
			uac_pkg::OP_INC: simple_val = head.x + W'(1);
			uac_pkg::OP_DEC: simple_val = head.x - W'(1);
			default:         simple_val = '0;
		endcase
	end

	// multiply operand select: low x low, then the two cross terms
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				mul_a = a_q[H-1:0];
				mul_b = b_q[H-1:0];
			end
			2'd1: begin
				mul_a = a_q[H-1:0];
				mul_b = b_q[W-1:H];
			end
			default: begin
				mul_a = a_q[W-1:H];
				mul_b = b_q[H-1:0];
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;
	assign acc_sum  = acc_q + {prod_q[H-1:0], {H{1'b0}}};

	// one restoring division step, carry bit kept on top of the remainder
	assign div_t    = {rem_q, a_q[W-1]};
	assign div_diff = {1'b0, div_t} - {2'b00, b_q};
	assign take     = !div_diff[W+1];
	assign rem_next = take ? div_diff[W-1:0] : div_t[W-1:0];
	assign quo_next = {quo_q[W-2:0], take};

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uac_pkg::ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				uac_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						unique case (head.cls)
							uac_pkg::CLS_MUL: state_q <= uac_pkg::ST_MUL;
							uac_pkg::CLS_DIV: state_q <= uac_pkg::ST_DIV;
							default:          done_q  <= 1'b1;
						endcase
					end
				end
				uac_pkg::ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST) begin
						done_q  <= 1'b1;
						state_q <= uac_pkg::ST_IDLE;
					end
				end
				uac_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						done_q  <= 1'b1;
						state_q <= uac_pkg::ST_IDLE;
					end
				end
				default: state_q <= uac_pkg::ST_IDLE;
			endcase
		end
	end

	// operand, partial result and output registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			uac_pkg::ST_IDLE: begin
				if (pop) begin
					a_q      <= head.x;
					b_q      <= head.y;
					is_mod_q <= head.x_op == uac_pkg::OP_MOD;
					lt_q     <= head.less;
					eq_q     <= head.equal;
					rem_q    <= '0;
					quo_q    <= '0;
					if (head.cls == uac_pkg::CLS_SIMPLE) begin
						value_q <= simple_val;
						less_q  <= head.less;
						equal_q <= head.equal;
					end
				end
			end
			uac_pkg::ST_MUL: begin
				prod_q <= mul_prod;
				if (cnt_q == 6'd1) begin
					acc_q <= prod_q;
				end else if (cnt_q != '0) begin
					acc_q <= acc_sum;
				end
				if (cnt_q == MUL_LAST) begin
					value_q <= acc_sum;
					less_q  <= lt_q;
					equal_q <= eq_q;
				end
			end
			uac_pkg::ST_DIV: begin
				a_q   <= {a_q[W-2:0], 1'b0};
				rem_q <= rem_next;
				quo_q <= quo_next;
				if (cnt_q == DIV_LAST) begin
					value_q <= is_mod_q ? rem_next : quo_next;
					less_q  <= lt_q;
					equal_q <= eq_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

// ===== hdl/unsigned_64bit_alu_core.sv =====
// unsigned_64bit_alu_core: top level of the unsigned 64-bit alu
// depends on uac_pkg, uac_front, uac_queue, uac_back
`timescale 1ns / 1ps

// usage
// - a request (op, operand_x, operand_y, shift_amount) is taken at a rising
//   edge with start high and busy low; busy rises while the two entry
//   request queue is full
// - each request gives one result: value, less, equal on the result ports
//   for exactly one cycle with done high; results come out in request order
// - path from the accepting edge to the done cycle, with the back end free:
//   add, sub, shl, shr, and, inc, dec and unused opcodes: queue, then value_q
//   mul: queue, ST_MUL (three 32x32 partial products through one multiplier)
//   div, mod: queue, ST_DIV (one quotient bit per cycle, 64 steps)
// - throughput is set by the back end: one simple op per cycle while it is idle;
//   a mul, div or mod holds it, and no new request is popped until it is back in ST_IDLE
// - the receiver cannot stall; a result is shown once and must be taken
// - less and equal compare operand_x with operand_y for every opcode
// - division by zero gives an all-ones quotient and a remainder equal to x
// - arst_n clears the queue and the sequencer; no request is pending after it

module unsigned_64bit_alu_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  uac_pkg::op_t                op,
	input  logic [uac_pkg::WORD_W-1:0]  operand_x,
	input  logic [uac_pkg::WORD_W-1:0]  operand_y,
	input  logic [uac_pkg::SHIFT_W-1:0] shift_amount,
	output logic                        done,
	output logic [uac_pkg::WORD_W-1:0]  value,
	output logic                        less,
	output logic                        equal
);

	uac_pkg::q_status_t q_status;
	uac_pkg::item_t     push_item;
	uac_pkg::item_t     head;
	logic               push;
	logic               pop;

	// request accept and classification
	uac_front u_front (
		.start        (start),
		.op           (op),
		.operand_x    (operand_x),
		.operand_y    (operand_y),
		.shift_amount (shift_amount),
		.q_status     (q_status),
		.busy         (busy),
		.push         (push),
		.item         (push_item)
	);

	// decoupling queue
	uac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	// execution
	uac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.done     (done),
		.value    (value),
		.less     (less),
		.equal    (equal)
	);

endmodule

// ===== hdl/uac_checker.sv =====
// uac_checker: port level assertions for unsigned_64bit_alu_core, bound to it
// depends on uac_pkg and the top level's ports
`timescale 1ns / 1ps

module uac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input uac_pkg::op_t                op,
	input logic [uac_pkg::WORD_W-1:0]  operand_x,
	input logic [uac_pkg::WORD_W-1:0]  operand_y,
	input logic                        done,
	input logic [uac_pkg::WORD_W-1:0]  value,
	input logic                        less,
	input logic                        equal
);

	logic [2:0] pending_q;
	logic       accept;

	assign accept = start && !busy;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !done) begin
			pending_q <= pending_q + 1'b1;
		end else if (done && !accept) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// no result without an open request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pending_q != '0)
		else $error("result with no open request");

	// busy only with a full queue behind it
	a_busy_backed: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> pending_q >= 3'd2)
		else $error("busy with fewer than two open requests");

	// flags are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(less && equal))
		else $error("less and equal both set");

	// an add into an idle block is answered with the sum, through the queue and the back end's result register
	a_add_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pending_q == '0 && op == uac_pkg::OP_ADD) |-> ##2
		(done && value == $past(operand_x, 2) + $past(operand_y, 2)))
		else $error("add on idle block gave wrong or late result");

endmodule

bind unsigned_64bit_alu_core uac_checker u_uac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.op        (op),
	.operand_x (operand_x),
	.operand_y (operand_y),
	.done      (done),
	.value     (value),
	.less      (less),
	.equal     (equal)
);
